@@ rtl/core/ole_pkg.sv @@
package ole_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int POS_W      = 8;
   localparam int IXW        = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request codes
   localparam logic [3:0] OP_INS_HEAD = 4'd0;
   localparam logic [3:0] OP_INS_TAIL = 4'd1;
   localparam logic [3:0] OP_INS_POS  = 4'd2;
   localparam logic [3:0] OP_DEL_HEAD = 4'd3;
   localparam logic [3:0] OP_DEL_TAIL = 4'd4;
   localparam logic [3:0] OP_DEL_POS  = 4'd5;
   localparam logic [3:0] OP_SEARCH   = 4'd6;
   localparam logic [3:0] OP_DUMP     = 4'd7;
   localparam logic [3:0] OP_CLEAR    = 4'd8;

   // result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_MISS  = 2'd3;

   // read address select
   localparam logic [2:0] RA_ZERO   = 3'd0;
   localparam logic [2:0] RA_IDX    = 3'd1;
   localparam logic [2:0] RA_CNT_M1 = 3'd2;
   localparam logic [2:0] RA_UP     = 3'd3;
   localparam logic [2:0] RA_DN     = 3'd4;

   // write select
   localparam logic [1:0] WA_IDX    = 2'd0;
   localparam logic [1:0] WA_PTR_UP = 2'd1;
   localparam logic [1:0] WA_PTR_DN = 2'd2;

   // count update
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_INC  = 2'd1;
   localparam logic [1:0] CNT_DEC  = 2'd2;
   localparam logic [1:0] CNT_CLR  = 2'd3;

   // result value select
   localparam logic [1:0] VS_ZERO    = 2'd0;
   localparam logic [1:0] VS_RDATA   = 2'd1;
   localparam logic [1:0] VS_REMOVED = 2'd2;

   typedef struct packed {
      logic [3:0]         req_type;
      logic signed [31:0] value;
      logic [POS_W-1:0]   position;
   } ole_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_out;
      logic [8:0]         position_out;
      logic [4:0]         count;
      logic               last;
   } ole_rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_en;
      logic [2:0] rd_sel;
      logic       wr_en;
      logic [1:0] wr_sel;
      logic [1:0] cnt_op;
      logic       cap_removed;
      logic       emit;
      logic [1:0] rsp_status;
      logic [1:0] rsp_val_sel;
      logic       rsp_pos_en;
      logic       rsp_last;
   } ole_cmd_type;

   typedef struct packed {
      logic [3:0] req_type;
      logic       full;
      logic       empty;
      logic       idx_at_end;
      logic       del_valid;
      logic       ptr_at_idx;
      logic       ptr_at_end;
      logic       match;
      logic       out_free;
   } ole_stat_type;

endpackage

@@ rtl/core/ole_dpath.sv @@
module ole_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  ole_pkg::ole_req_type  req_data,
   input  ole_pkg::ole_cmd_type  cmd,
   output ole_pkg::ole_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ole_pkg::ole_rsp_type  rsp_data
);
   import ole_pkg::*;

   logic [31:0]      mem [LIST_DEPTH];
   logic [31:0]      rdata_ff;
   logic [31:0]      removed_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   ole_req_type      req_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   ole_rsp_type      rsp_ff;
   ole_rsp_type      rsp_in;

   logic [IXW-1:0]   idx;
   logic [IXW-1:0]   cnt_x;
   logic [IXW-1:0]   pos_m1;
   logic [IDX_W-1:0] idx_a;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;
   logic [31:0]      removed_val;

   assign cnt_x  = IXW'(cnt_ff);
   assign pos_m1 = IXW'(req_ff.position) - IXW'(1);

   // target index of an insert or delete
   always_comb begin
      case (req_ff.req_type)
         OP_INS_HEAD: idx = '0;
         OP_INS_TAIL: idx = cnt_x;
         OP_INS_POS: begin
            if (req_ff.position == '0) begin
               idx = '0;
            end else if (pos_m1 > cnt_x) begin
               idx = cnt_x;
            end else begin
               idx = pos_m1;
            end
         end
         OP_DEL_HEAD: idx = '0;
         OP_DEL_TAIL: idx = (cnt_ff == '0) ? '0 : cnt_x - IXW'(1);
         OP_DEL_POS:  idx = (req_ff.position == '0) ? cnt_x : pos_m1;
         default:     idx = '0;
      endcase
   end

   assign idx_a = idx[IDX_W-1:0];

   always_comb begin
      stat.req_type   = req_ff.req_type;
      stat.full       = (cnt_ff == CNT_W'(LIST_DEPTH));
      stat.empty      = (cnt_ff == '0);
      stat.idx_at_end = (idx == cnt_x);
      stat.del_valid  = (cnt_ff != '0) && (idx < cnt_x);
      stat.ptr_at_idx = (IXW'(ptr_ff) == idx);
      stat.ptr_at_end = (CNT_W'(ptr_ff) == cnt_ff - CNT_W'(1));
      stat.match      = (rdata_ff == $unsigned(req_ff.value));
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      case (cmd.rd_sel)
         RA_ZERO:   rd_addr = '0;
         RA_IDX:    rd_addr = idx_a;
         RA_CNT_M1: rd_addr = IDX_W'(cnt_ff - CNT_W'(1));
         RA_UP:     rd_addr = ptr_ff + IDX_W'(1);
         RA_DN:     rd_addr = ptr_ff - IDX_W'(1);
         default:   rd_addr = '0;
      endcase
   end

   always_comb begin
      case (cmd.wr_sel)
         WA_IDX: begin
            wr_addr = idx_a;
            wr_data = $unsigned(req_ff.value);
         end
         WA_PTR_UP: begin
            wr_addr = ptr_ff + IDX_W'(1);
            wr_data = rdata_ff;
         end
         WA_PTR_DN: begin
            wr_addr = ptr_ff - IDX_W'(1);
            wr_data = rdata_ff;
         end
         default: begin
            wr_addr = idx_a;
            wr_data = rdata_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC: cnt_in = cnt_ff + CNT_W'(1);
         CNT_DEC: cnt_in = cnt_ff - CNT_W'(1);
         CNT_CLR: cnt_in = '0;
         default: cnt_in = cnt_ff;
      endcase
   end

   // removed element is in rdata on the first step of a delete walk
   assign removed_val = stat.ptr_at_idx ? rdata_ff : removed_ff;

   always_comb begin
      rsp_in.status = cmd.rsp_status;
      case (cmd.rsp_val_sel)
         VS_RDATA:   rsp_in.value_out = rdata_ff;
         VS_REMOVED: rsp_in.value_out = removed_val;
         default:    rsp_in.value_out = '0;
      endcase
      rsp_in.position_out = cmd.rsp_pos_en ? 9'(ptr_ff) + 9'd1 : 9'd0;
      rsp_in.count        = 5'(cnt_in);
      rsp_in.last         = cmd.rsp_last;
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.rd_en) begin
         ptr_ff <= rd_addr;
      end
      if (cmd.cap_removed) begin
         removed_ff <= rdata_ff;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/core/ole_ctrl.sv @@
module ole_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ole_pkg::ole_stat_type stat,
   output ole_pkg::ole_cmd_type  cmd
);
   import ole_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_INS     = 3'd2;
   localparam logic [2:0] S_INS_PUT = 3'd3;
   localparam logic [2:0] S_DEL     = 3'd4;
   localparam logic [2:0] S_SRCH    = 3'd5;
   localparam logic [2:0] S_DUMP    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.rd_sel      = RA_ZERO;
      cmd.wr_sel      = WA_IDX;
      cmd.cnt_op      = CNT_HOLD;
      cmd.rsp_status  = ST_DONE;
      cmd.rsp_val_sel = VS_ZERO;
      cmd.rsp_last    = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.req_type)
               OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                  if (stat.full) begin
                     if (stat.out_free) begin
                        cmd.emit       = 1'b1;
                        cmd.rsp_status = ST_FULL;
                        state_in       = S_IDLE;
                     end
                  end else if (stat.idx_at_end) begin
                     if (stat.out_free) begin
                        cmd.wr_en  = 1'b1;
                        cmd.cnt_op = CNT_INC;
                        cmd.emit   = 1'b1;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RA_CNT_M1;
                     state_in   = S_INS;
                  end
               end
               OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
                  if (!stat.del_valid) begin
                     if (stat.out_free) begin
                        cmd.emit       = 1'b1;
                        cmd.rsp_status = ST_EMPTY;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RA_IDX;
                     state_in   = S_DEL;
                  end
               end
               OP_SEARCH, OP_DUMP: begin
                  if (stat.empty) begin
                     if (stat.out_free) begin
                        cmd.emit       = 1'b1;
                        cmd.rsp_status = (stat.req_type == OP_SEARCH) ? ST_MISS : ST_EMPTY;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RA_ZERO;
                     state_in   = (stat.req_type == OP_SEARCH) ? S_SRCH : S_DUMP;
                  end
               end
               OP_CLEAR: begin
                  if (stat.out_free) begin
                     cmd.cnt_op = CNT_CLR;
                     cmd.emit   = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
               default: begin
                  if (stat.out_free) begin
                     cmd.emit = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_INS: begin
            // move the element read last cycle one slot toward the tail
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WA_PTR_UP;
            if (stat.ptr_at_idx) begin
               state_in = S_INS_PUT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_DN;
            end
         end
         S_INS_PUT: begin
            if (stat.out_free) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WA_IDX;
               cmd.cnt_op = CNT_INC;
               cmd.emit   = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DEL: begin
            // a stall at the end repeats the same write, which is harmless
            if (stat.ptr_at_idx) begin
               cmd.cap_removed = 1'b1;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WA_PTR_DN;
            end
            if (stat.ptr_at_end) begin
               if (stat.out_free) begin
                  cmd.cnt_op      = CNT_DEC;
                  cmd.emit        = 1'b1;
                  cmd.rsp_val_sel = VS_REMOVED;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_UP;
            end
         end
         S_SRCH: begin
            if (stat.match) begin
               if (stat.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.rsp_pos_en = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (stat.ptr_at_end) begin
               if (stat.out_free) begin
                  cmd.emit       = 1'b1;
                  cmd.rsp_status = ST_MISS;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_UP;
            end
         end
         S_DUMP: begin
            if (stat.out_free) begin
               cmd.emit        = 1'b1;
               cmd.rsp_val_sel = VS_RDATA;
               cmd.rsp_pos_en  = 1'b1;
               cmd.rsp_last    = stat.ptr_at_end;
               if (stat.ptr_at_end) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RA_UP;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/ordered_list_engine.sv @@
// Ordered list of up to LIST_DEPTH (16) signed 32-bit values in a register file with one write
// and one registered read per cycle. One item is worked at a time; the next is taken once the
// last result of the current one is loaded into the output register. Insert at the tail, delete
// with nothing to remove, clear and full-list inserts need no walk; other inserts and deletes
// shift the elements behind the position, a search walks until it finds a match or reaches the
// tail, and a dump gives one result per cycle while the result channel is free. Walks through
// the register file take one element per cycle. A stalled result channel holds the engine
// before each result is loaded; an insert, delete or search walk is held only at its last step.
module ordered_list_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ole_pkg::ole_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ole_pkg::ole_rsp_type rsp_data
);
   import ole_pkg::*;

   ole_cmd_type  cmd;
   ole_stat_type stat;

   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ole_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
